/* hdl/rde_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, limits and the digit glyph function for the radix digit emitter.
// No dependencies. Used by rde_div and radix_digit_emitter_core.
package rde_pkg;

  localparam int VAL_W      = 63;
  localparam int RDX_W      = 5;
  localparam int REM_W      = 4;
  localparam int CHAR_W     = 7;
  localparam int MAX_DIGITS = 64;
  localparam int RUN_CAP    = (MAX_DIGITS < VAL_W) ? MAX_DIGITS : VAL_W;
  localparam int IDX_W      = $clog2(RUN_CAP);
  localparam int CNT_W      = $clog2(RUN_CAP + 1);
  localparam int STEP_W     = $clog2(VAL_W);

  localparam logic [RDX_W-1:0]  RADIX_MIN = RDX_W'(2);
  localparam logic [RDX_W-1:0]  RADIX_MAX = RDX_W'(16);
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Maps a digit 0..15 to its ASCII character 0-9, A-F.
  function automatic logic [CHAR_W-1:0] glyph(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < REM_W'(10)) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return ch;
  endfunction

endpackage

/* hdl/rde_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle by a small divisor.
// Depends on rde_pkg.
module rde_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rde_pkg::div_ctl_t          ctl,
  input  logic [rde_pkg::VAL_W-1:0]  dividend,
  input  logic [rde_pkg::RDX_W-1:0]  divisor,
  output rde_pkg::div_stat_t         stat,
  output logic [rde_pkg::VAL_W-1:0]  quotient,
  output logic [rde_pkg::REM_W-1:0]  remainder
);
  import rde_pkg::*;

  logic [VAL_W-1:0]  q_r;
  logic [REM_W-1:0]  rem_r;
  logic [RDX_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [RDX_W-1:0]  shifted;
  logic              ge;
  logic [RDX_W-1:0]  diff;

  // The remainder stays below the divisor, so the shifted value fits in RDX_W bits.
  assign shifted = {rem_r, q_r[VAL_W-1]};
  assign ge      = (shifted >= div_r);
  assign diff    = shifted - div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[VAL_W-2:0], ge};
      rem_r <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end
  end

  assign stat      = {busy_r, done_r};
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* hdl/radix_digit_emitter_core.sv */
`timescale 1ns / 1ps
// Top level of the radix digit emitter: sequencer, digit buffer and output register.
// Depends on rde_pkg and rde_div.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_value, in_radix
//   out     | output    | out_valid / out_stall| out_digit_char, out_last_digit, out_bad_radix
//
// Each digit costs one pass of the shared bit-serial divider (one bit per cycle
// over 63 bits after the load), so a value of n digits takes n passes of division,
// then a read state and a write state per digit to read the buffer out, stalls aside.
// A zero value or a bad radix gives its single result from S_SINGLE once the output is free.
// Reset is synchronous and clears the sequencer and the output valid flag.
// A stalled output holds its result; the next input transfer is taken once the
// block is idle, even while the last result still waits.
module radix_digit_emitter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rde_pkg::VAL_W-1:0]   in_value,
  input  logic [rde_pkg::RDX_W-1:0]   in_radix,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rde_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit,
  output logic                        out_bad_radix
);
  import rde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIV,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              spec_bad_r, spec_bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic [REM_W-1:0]  dig_mem [RUN_CAP];
  logic [REM_W-1:0]  rd_data_r;

  div_ctl_t          div_ctl;
  div_stat_t         div_stat;
  logic [VAL_W-1:0]  div_dividend;
  logic [RDX_W-1:0]  div_divisor;
  logic [VAL_W-1:0]  div_quot;
  logic [REM_W-1:0]  div_rem;
  logic [RDX_W-1:0]  radix_r;

  logic in_xfer;
  logic radix_bad;
  logic out_free;
  logic run_end;
  logic mem_we;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && (state_r == S_IDLE);
  assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign out_free  = !out_valid_r || !out_stall;
  assign run_end   = (div_quot == '0) || (cnt_r == CNT_W'(RUN_CAP - 1));
  assign mem_we    = (state_r == S_DIV) && div_stat.done;

  // The first division starts from the input; later ones from the last quotient.
  assign div_dividend = (state_r == S_IDLE) ? in_value : div_quot;
  assign div_ctl      = (in_xfer && !radix_bad && (in_value != '0)) ||
                        (mem_we && !run_end);

  // The divider latches the divisor only on start; the radix is needed only then
  // from the port, and later restarts reuse the stored copy.
  assign div_divisor = (state_r == S_IDLE) ? in_radix : radix_r;

  rde_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      radix_r <= in_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dig_mem[cnt_r[IDX_W-1:0]] <= div_rem;
    end
    rd_data_r <= dig_mem[rd_idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    spec_bad_nxt  = spec_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = '0;
          if (radix_bad || (in_value == '0)) begin
            spec_bad_nxt = radix_bad;
            state_nxt    = S_SINGLE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = spec_bad_r;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (run_end) begin
            rd_idx_nxt = cnt_r[IDX_W-1:0];
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = glyph(rd_data_r);
          out_last_nxt  = (rd_idx_r == '0);
          out_bad_nxt   = 1'b0;
          if (rd_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - IDX_W'(1);
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
    spec_bad_r <= spec_bad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;
  assign out_bad_radix  = out_bad_r;

endmodule

/* tb/rde_digit_checker.sv */
`timescale 1ns / 1ps
// Watches both channels of the radix digit emitter, predicts the digit stream of every
// accepted conversion and compares each output transfer. Depends on rde_pkg.
module rde_digit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [rde_pkg::VAL_W-1:0]   in_value,
  input  logic [rde_pkg::RDX_W-1:0]   in_radix,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [rde_pkg::CHAR_W-1:0]  out_digit_char,
  input  logic                        out_last_digit,
  input  logic                        out_bad_radix,
  output int                          err_count,
  output int                          pending,
  output int                          conversions,
  output int                          digits_seen
);

  typedef struct packed {
    logic [rde_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       bad;
  } digit_rec_t;

  localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

  digit_rec_t pending_chars[$];
  digit_rec_t want;
  int         errs = 0;
  int         n_conv = 0;
  int         n_digits = 0;

  initial begin
    err_count   = 0;
    pending     = 0;
    conversions = 0;
    digits_seen = 0;
  end

  // Queues the characters one conversion should produce, most significant first.
  task automatic convert_to_chars(input logic [rde_pkg::VAL_W-1:0] v,
                                  input logic [rde_pkg::RDX_W-1:0] r);
    int                       rems [0:63];
    logic [rde_pkg::VAL_W-1:0] rest;
    int                       n;
    int                       k;
    digit_rec_t               rec;
    rec.ch   = rde_pkg::CHAR_ZERO;
    rec.last = 1'b1;
    rec.bad  = 1'b0;
    if (r < rde_pkg::RADIX_MIN || r > rde_pkg::RADIX_MAX) begin
      rec.bad = 1'b1;
      pending_chars.push_back(rec);
    end else if (v == '0) begin
      pending_chars.push_back(rec);
    end else begin
      rest = v;
      n = 0;
      while (rest != '0 && n < rde_pkg::RUN_CAP) begin
        rems[n] = int'(rest % r);
        rest = rest / r;
        n++;
      end
      for (k = n - 1; k >= 0; k--) begin
        rec.ch   = rde_pkg::CHAR_W'(GLYPHS[(15 - rems[k]) * 8 +: 8]);
        rec.last = (k == 0);
        pending_chars.push_back(rec);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Outputs are checked before the new transfer is queued; a result never
      // belongs to an input accepted on the same edge.
      if (out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected digit transfer: char=%0d last=%0d bad=%0d",
                   $time, out_digit_char, out_last_digit, out_bad_radix);
          errs++;
        end else begin
          want = pending_chars.pop_front();
          if (out_digit_char !== want.ch) begin
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, want.ch, out_digit_char);
            errs++;
          end
          if (out_last_digit !== want.last) begin
            $display("%0t: last_digit mismatch: expected %0d, actual %0d",
                     $time, want.last, out_last_digit);
            errs++;
          end
          if (out_bad_radix !== want.bad) begin
            $display("%0t: bad_radix mismatch: expected %0d, actual %0d",
                     $time, want.bad, out_bad_radix);
            errs++;
          end
          n_digits++;
        end
      end
      if (in_valid && !in_stall) begin
        convert_to_chars(in_value, in_radix);
        n_conv++;
      end
    end
    err_count   <= errs;
    pending     <= pending_chars.size();
    conversions <= n_conv;
    digits_seen <= n_digits;
  end

endmodule

/* tb/tb_radix_digit_emitter_core.sv */
`timescale 1ns / 1ps
// Top of the radix digit emitter testbench: clock, reset, stimulus and verdict.
// Depends on rde_pkg, radix_digit_emitter_core and rde_digit_checker.
module tb_radix_digit_emitter_core;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int N_RANDOM    = 140;
  localparam logic [rde_pkg::VAL_W-1:0] VAL_MAX = {rde_pkg::VAL_W{1'b1}};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [rde_pkg::VAL_W-1:0]   in_value = '0;
  logic [rde_pkg::RDX_W-1:0]   in_radix = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [rde_pkg::CHAR_W-1:0]  out_digit_char;
  logic                        out_last_digit;
  logic                        out_bad_radix;

  int   err_count;
  int   pending;
  int   conversions;
  int   digits_seen;
  int   cycles = 0;
  logic no_idle = 1'b0;

  always #2 clk = ~clk;

  radix_digit_emitter_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_bad_radix  (out_bad_radix)
  );

  rde_digit_checker digit_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_bad_radix  (out_bad_radix),
    .err_count      (err_count),
    .pending        (pending),
    .conversions    (conversions),
    .digits_seen    (digits_seen)
  );

  always @(posedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 21);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one conversion and returns at the edge where it transfers.
  // in_stall is looked at on the falling edge, where it is settled.
  task automatic send_item(input logic [rde_pkg::VAL_W-1:0] v,
                           input logic [rde_pkg::RDX_W-1:0] r);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_radix <= r;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [rde_pkg::VAL_W-1:0] rand_value();
    logic [63:0] full;
    int          len;
    full = {$urandom, $urandom};
    len  = $urandom_range(0, rde_pkg::VAL_W);
    // Spread the bit length so that short and long digit runs both occur.
    if (len < rde_pkg::VAL_W) begin
      full = full & ((64'd1 << len) - 64'd1);
    end
    return full[rde_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [rde_pkg::RDX_W-1:0] rand_bad_radix();
    int k;
    k = $urandom_range(0, 16);
    return (k < 2) ? rde_pkg::RDX_W'(k) : rde_pkg::RDX_W'(k + 15);
  endfunction

  initial begin
    logic [rde_pkg::VAL_W-1:0] v;
    logic [rde_pkg::RDX_W-1:0] r;
    int                        i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero values, the largest value, single digits and invalid bases.
    send_item('0, 5'd10);
    send_item('0, 5'd2);
    send_item('0, 5'd16);
    send_item(VAL_MAX, 5'd2);
    send_item(VAL_MAX, 5'd16);
    send_item(VAL_MAX, 5'd10);
    send_item(VAL_MAX, 5'd3);
    send_item(63'd1, 5'd2);
    send_item(63'd15, 5'd16);
    send_item(63'd16, 5'd16);
    send_item(63'd10, 5'd10);
    send_item(63'd123, 5'd0);
    send_item(VAL_MAX, 5'd1);
    send_item('0, 5'd17);
    send_item(63'd5, 5'd31);
    for (i = 4; i <= 15; i++) begin
      if (i != 7 && i != 10) begin
        send_item(VAL_MAX, rde_pkg::RDX_W'(i));
      end
    end

    for (i = 0; i < N_RANDOM; i++) begin
      no_idle <= (i >= 50 && i < 80);
      if ($urandom_range(0, 99) < 85) begin
        r = rde_pkg::RDX_W'($urandom_range(2, 16));
      end else begin
        r = rand_bad_radix();
      end
      v = ($urandom_range(0, 19) == 0) ? '0 : rand_value();
      send_item(v, r);
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Ran %0d conversions over bases 0 to 31, %0d digit transfers checked,",
             conversions, digits_seen);
    $display("including zero values, full-width values and invalid bases.");
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
